/* rtl/core/queue_stack_buffer_core_assert.svh */
// ----------------------------------------------------------------------------
// queue_stack_buffer_core_assert.svh
// Assertion macros shared by the buffer core modules (clk_i / rst_ni domain).
// ----------------------------------------------------------------------------
`ifndef QUEUE_STACK_BUFFER_CORE_ASSERT_SVH
`define QUEUE_STACK_BUFFER_CORE_ASSERT_SVH

// Condition must hold whenever the trigger holds.
`define QSB_ASSERT_NOW(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cond)) \
    else $error(msg);

// Condition must hold in the cycle after the trigger.
`define QSB_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

/* rtl/core/qsb_pkg.sv */
// ----------------------------------------------------------------------------
// qsb_pkg
// Types and constants of the queue/stack buffer core.
// ----------------------------------------------------------------------------
package qsb_pkg;

  localparam int unsigned DEPTH_DEFAULT = 128;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned IDX_W         = 7;
  localparam int unsigned OCC_W         = 8;

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_READ = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MOP_NONE  = 2'd0,
    MOP_WRITE = 2'd1,
    MOP_READ  = 2'd2
  } mem_op_e;

  // Control part of a request handed from front to back.
  typedef struct packed {
    mem_op_e           op;
    status_e           status;
    logic [OCC_W-1:0]  occupancy;
  } meta_t;

  localparam int unsigned META_W = $bits(meta_t);

endpackage

/* rtl/core/qsb_if.sv */
// ----------------------------------------------------------------------------
// qsb_if
// Valid/ready channel interfaces for commands and results.
// ----------------------------------------------------------------------------
interface qsb_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        command;
  logic signed [qsb_pkg::WORD_W-1:0] push_value;
  logic [qsb_pkg::IDX_W-1:0]         index;

  modport source (output valid, command, push_value, index, input ready);
  modport sink   (input valid, command, push_value, index, output ready);
endinterface

interface qsb_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [qsb_pkg::WORD_W-1:0] value;
  logic [1:0]                        status;
  logic [qsb_pkg::OCC_W-1:0]         occupancy;

  modport source (output valid, value, status, occupancy, input ready);
  modport sink   (input valid, value, status, occupancy, output ready);
endinterface

/* rtl/core/qsb_fifo.sv */
// ----------------------------------------------------------------------------
// qsb_fifo
// Two-entry request queue between the front and back parts.
// ----------------------------------------------------------------------------
module qsb_fifo #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] push_data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] head_o
);

  logic [W-1:0] data_q [2];
  logic         wr_q, wr_d;
  logic         rd_q, rd_d;
  logic [1:0]   cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q ^ push_i;
    rd_d  = rd_q ^ pop_i;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q[wr_q] <= push_data_i;
    end
  end

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign head_o  = data_q[rd_q];

endmodule

/* rtl/core/qsb_front.sv */
// ----------------------------------------------------------------------------
// qsb_front
// Takes commands, checks them against the count, moves the pointers and
// turns each into a store request with its status and new occupancy.
// ----------------------------------------------------------------------------
`include "queue_stack_buffer_core_assert.svh"

module qsb_front #(
  parameter int unsigned DEPTH = qsb_pkg::DEPTH_DEFAULT,
  localparam int unsigned AW   = $clog2(DEPTH),
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_wdata_i,
  qsb_in_if.sink                 req_i,
  input  logic                   q_full_i,
  output logic                   q_push_o,
  output qsb_pkg::meta_t         q_meta_o,
  output logic [AW-1:0]          q_addr_o,
  output logic [qsb_pkg::WORD_W-1:0] q_data_o
);

  localparam int unsigned IW = (CW > qsb_pkg::IDX_W) ? CW : qsb_pkg::IDX_W;

  logic          mode_q;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          accept;
  logic          full;
  logic          empty;

  // Slot that lies off entries beyond the oldest one, wrapped at DEPTH.
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign req_i.ready = !q_full_i;
  assign accept      = req_i.valid && req_i.ready;
  assign full        = cnt_q == CW'(DEPTH);
  assign empty       = cnt_q == '0;

  always_comb begin
    ptr_d            = ptr_q;
    cnt_d            = cnt_q;
    q_meta_o.op      = qsb_pkg::MOP_NONE;
    q_meta_o.status  = qsb_pkg::ST_OK;
    q_addr_o         = ptr_q;
    q_data_o         = req_i.push_value;
    case (qsb_pkg::cmd_e'(req_i.command))
      qsb_pkg::CMD_PUSH: begin
        if (full) begin
          q_meta_o.status = qsb_pkg::ST_FULL;
        end else begin
          q_meta_o.op = qsb_pkg::MOP_WRITE;
          q_addr_o    = slot(ptr_q, AW'(cnt_q));
          cnt_d       = cnt_q + CW'(1);
        end
      end
      qsb_pkg::CMD_POP: begin
        if (empty) begin
          q_meta_o.status = qsb_pkg::ST_UNDERFLOW;
        end else begin
          q_meta_o.op = qsb_pkg::MOP_READ;
          cnt_d       = cnt_q - CW'(1);
          if (mode_q) begin
            q_addr_o = slot(ptr_q, AW'(cnt_d));
          end else begin
            q_addr_o = ptr_q;
            ptr_d    = slot(ptr_q, AW'(1));
          end
        end
      end
      qsb_pkg::CMD_READ: begin
        if (IW'(req_i.index) >= IW'(cnt_q)) begin
          q_meta_o.status = qsb_pkg::ST_RANGE;
        end else begin
          q_meta_o.op = qsb_pkg::MOP_READ;
          q_addr_o    = slot(ptr_q, AW'(req_i.index));
        end
      end
      default: begin
      end
    endcase
    q_meta_o.occupancy = qsb_pkg::OCC_W'(cnt_d);
  end

  assign q_push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      ptr_q  <= '0;
      cnt_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (accept) begin
        ptr_q <= ptr_d;
        cnt_q <= cnt_d;
      end
    end
  end

  `QSB_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CW'(DEPTH), "count above depth")
  `QSB_ASSERT_NEXT(a_full_drop, accept && full &&
                   req_i.command == qsb_pkg::CMD_PUSH,
                   cnt_q == CW'(DEPTH), "dropped push changed count")
  `QSB_ASSERT_NEXT(a_read_keeps, accept && req_i.command == qsb_pkg::CMD_READ,
                   $stable(cnt_q) && $stable(ptr_q), "read moved pointers")

endmodule

/* rtl/core/qsb_back.sv */
// ----------------------------------------------------------------------------
// qsb_back
// Carries out store requests on the word memory and holds the result
// register toward the output channel.
// ----------------------------------------------------------------------------
`include "queue_stack_buffer_core_assert.svh"

module qsb_back #(
  parameter int unsigned DEPTH = qsb_pkg::DEPTH_DEFAULT,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  input  qsb_pkg::meta_t             q_meta_i,
  input  logic [AW-1:0]              q_addr_i,
  input  logic [qsb_pkg::WORD_W-1:0] q_data_i,
  output logic                       q_pop_o,
  qsb_out_if.source                  rsp_o
);

  logic [qsb_pkg::WORD_W-1:0] mem [DEPTH];
  logic [qsb_pkg::WORD_W-1:0] rd_q;
  qsb_pkg::meta_t             meta_q;
  logic                       out_valid_q;
  logic                       advance;

  // Result register frees up when empty or being taken this cycle.
  assign advance = !out_valid_q || rsp_o.ready;
  assign q_pop_o = advance && q_valid_i;

  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_meta_i.op == qsb_pkg::MOP_WRITE) begin
      mem[q_addr_i] <= q_data_i;
    end
    if (q_pop_o && q_meta_i.op == qsb_pkg::MOP_READ) begin
      rd_q <= mem[q_addr_i];
    end
    if (q_pop_o) begin
      meta_q <= q_meta_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= q_valid_i;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.value     = (meta_q.op == qsb_pkg::MOP_READ) ? rd_q : '0;
  assign rsp_o.status    = meta_q.status;
  assign rsp_o.occupancy = meta_q.occupancy;

  `QSB_ASSERT_NEXT(a_rd_hold, out_valid_q && !rsp_o.ready, $stable(rd_q),
                   "read data moved under stall")
  `QSB_ASSERT_NOW(a_err_zero, out_valid_q && rsp_o.status != qsb_pkg::ST_OK,
                  rsp_o.value == '0, "error result carries a value")
  `QSB_ASSERT_NEXT(a_write_zero, q_pop_o && q_meta_i.op == qsb_pkg::MOP_WRITE,
                   out_valid_q && rsp_o.value == '0, "push result not zero")

endmodule

/* rtl/core/queue_stack_buffer_core.sv */
// ----------------------------------------------------------------------------
// queue_stack_buffer_core
// Fixed-depth buffer of signed words with queue or stack pop and indexed
// read. Front decodes commands and keeps the pointers, back owns the memory.
//
//   channel | dir | handshake        | payload
//   --------+-----+------------------+-------------------------------
//   req_i   | in  | valid/ready      | command, push_value, index
//   rsp_o   | out | valid/ready      | value, status, occupancy
//   cfg     | in  | cfg_we_i         | cfg_wdata_i (stack_mode)
//
// One request per cycle is taken while the two-entry queue has room.
// A request passes through the queue and then the registered memory access
// before its result appears.
// Output stalls fill the queue, then drop req_i.ready.
// No clearing pass after reset; memory contents are only read once written.
// ----------------------------------------------------------------------------
module queue_stack_buffer_core #(
  parameter int unsigned DEPTH = qsb_pkg::DEPTH_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  qsb_in_if.sink    req_i,
  qsb_out_if.source rsp_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned QW = qsb_pkg::META_W + AW + qsb_pkg::WORD_W;

  logic                       f_push;
  qsb_pkg::meta_t             f_meta;
  logic [AW-1:0]              f_addr;
  logic [qsb_pkg::WORD_W-1:0] f_data;
  logic                       q_full;
  logic                       q_valid;
  logic                       q_pop;
  logic [QW-1:0]              q_head;
  qsb_pkg::meta_t             b_meta;
  logic [AW-1:0]              b_addr;
  logic [qsb_pkg::WORD_W-1:0] b_data;

  qsb_front #(.DEPTH(DEPTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .q_full_i    (q_full),
    .q_push_o    (f_push),
    .q_meta_o    (f_meta),
    .q_addr_o    (f_addr),
    .q_data_o    (f_data)
  );

  qsb_fifo #(.W(QW)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (f_push),
    .push_data_i ({f_meta, f_addr, f_data}),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  assign {b_meta, b_addr, b_data} = q_head;

  qsb_back #(.DEPTH(DEPTH)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_meta_i  (b_meta),
    .q_addr_i  (b_addr),
    .q_data_i  (b_data),
    .q_pop_o   (q_pop),
    .rsp_o     (rsp_o)
  );

endmodule

/* tb/sv/qsb_scoreboard.sv */
// ----------------------------------------------------------------------------
// qsb_scoreboard
// Watches the request, result and mode-write traffic of the buffer core.
// It keeps its own copy of the circular word store and pointers, works out
// the result of every accepted request and checks each accepted result
// field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module qsb_scoreboard #(
  parameter int unsigned DEPTH = qsb_pkg::DEPTH_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  qsb_in_if           req_i,
  qsb_out_if          rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef logic [qsb_pkg::WORD_W-1:0] word_t;
  typedef logic [qsb_pkg::OCC_W-1:0]  occ_t;

  typedef struct packed {
    logic signed [qsb_pkg::WORD_W-1:0] value;
    qsb_pkg::status_e                  status;
    logic [qsb_pkg::OCC_W-1:0]         occupancy;
  } buf_result_t;

  logic signed [qsb_pkg::WORD_W-1:0] word_mem [DEPTH];
  int unsigned                       oldest;
  int unsigned                       held;
  bit                                lifo_mode;
  buf_result_t                       expected_q [$];
  int unsigned                       mismatches;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(string field, logic [qsb_pkg::WORD_W-1:0] got,
                                 logic [qsb_pkg::WORD_W-1:0] want);
    $display("%0t: mismatch on %s: got %0h, want %0h", $time, field, got, want);
    mismatches++;
  endtask

  function automatic int unsigned slot_from_oldest(int unsigned off);
    return (oldest + off) % DEPTH;
  endfunction

  function automatic buf_result_t apply_command(logic [1:0] cmd,
                                                logic signed [qsb_pkg::WORD_W-1:0] word,
                                                logic [qsb_pkg::IDX_W-1:0] idx);
    buf_result_t res;
    res.value  = '0;
    res.status = qsb_pkg::ST_OK;
    case (cmd)
      qsb_pkg::CMD_PUSH: begin
        if (held >= DEPTH) begin
          res.status = qsb_pkg::ST_FULL;
        end else begin
          word_mem[slot_from_oldest(held)] = word;
          held++;
        end
      end
      qsb_pkg::CMD_POP: begin
        if (held == 0) begin
          res.status = qsb_pkg::ST_UNDERFLOW;
        end else if (lifo_mode) begin
          res.value = word_mem[slot_from_oldest(held - 1)];
          held--;
        end else begin
          res.value = word_mem[oldest];
          oldest    = slot_from_oldest(1);
          held--;
        end
      end
      qsb_pkg::CMD_READ: begin
        if (idx >= held) res.status = qsb_pkg::ST_RANGE;
        else res.value = word_mem[slot_from_oldest(idx)];
      end
      default: ;  // unused code: no change, zero result
    endcase
    res.occupancy = occ_t'(held);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    buf_result_t want;
    if (!rst_ni) begin
      oldest    = 0;
      held      = 0;
      lifo_mode = 1'b0;
      expected_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) lifo_mode = cfg_wdata_i;
      if (req_i.valid && req_i.ready)
        expected_q.push_back(apply_command(req_i.command, req_i.push_value, req_i.index));
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", rsp_i.value, '0);
        end else begin
          want = expected_q.pop_front();
          if (rsp_i.value !== want.value)
            report_mismatch("value", rsp_i.value, want.value);
          if (rsp_i.status !== want.status)
            report_mismatch("status", word_t'(rsp_i.status), word_t'(want.status));
          if (rsp_i.occupancy !== want.occupancy)
            report_mismatch("occupancy", word_t'(rsp_i.occupancy), word_t'(want.occupancy));
        end
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

/* tb/sv/tb_queue_stack_buffer_core.sv */
// ----------------------------------------------------------------------------
// tb_queue_stack_buffer_core
// Drives the buffer core with a directed opening (empty pop, out-of-range
// reads, extreme words, unused command, mode change with words held) and then
// random phases that fill the buffer to full and drain it in both modes.
// Both channels idle at random; the result side also holds off for a long
// stretch so the core backs up. A scoreboard beside the core does the checks.
// ----------------------------------------------------------------------------
module tb_queue_stack_buffer_core;

  typedef logic signed [qsb_pkg::WORD_W-1:0] word_t;
  typedef logic [qsb_pkg::IDX_W-1:0]         idx_t;

  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LONG_HOLD   = 64;
  localparam int unsigned DRAIN_WAIT  = 8;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  bit          tx_idle_en  = 1'b1;
  bit          rx_idle_en  = 1'b1;
  bit          long_hold_tgl = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned fail_count;
  int unsigned pending;

  qsb_in_if  req_if ();
  qsb_out_if rsp_if ();

  queue_stack_buffer_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  qsb_scoreboard u_scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic word_t pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return -32'sd1;
      3:       return $urandom_range(0, 15);
      default: return $urandom();
    endcase
  endfunction

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int unsigned stall_left;
    bit          hold_seen;
    stall_left    = 0;
    hold_seen     = 1'b0;
    rsp_if.ready  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_tgl != hold_seen) begin
        hold_seen  = long_hold_tgl;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && rx_idle_en && $urandom_range(0, 99) < 20) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Leaves valid high on return; the caller sends again or drops valid
  // in the same step.
  task automatic send_request(logic [1:0] cmd, word_t word, idx_t idx);
    int unsigned gap;
    gap = tx_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.command    <= cmd;
    req_if.push_value <= word;
    req_if.index      <= idx;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
  endtask

  task automatic write_mode(bit lifo);
    drain_results();
    repeat (3) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lifo;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_random(int unsigned n, int unsigned push_pct, int unsigned pop_pct);
    int unsigned roll;
    logic [1:0]  cmd;
    idx_t        idx;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < push_pct) cmd = qsb_pkg::CMD_PUSH;
      else if (roll < push_pct + pop_pct) cmd = qsb_pkg::CMD_POP;
      else if (roll < 97) cmd = qsb_pkg::CMD_READ;
      else cmd = CMD_UNUSED;
      // half the reads near the oldest word so most of them hit
      idx = $urandom_range(0, 1) ? idx_t'($urandom_range(0, 127))
                                 : idx_t'($urandom_range(0, 15));
      send_request(cmd, pick_word(), idx);
    end
  endtask

  initial begin : stimulus
    req_if.valid      = 1'b0;
    req_if.command    = qsb_pkg::CMD_PUSH;
    req_if.push_value = '0;
    req_if.index      = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // queue mode from reset: empty cases, extremes, ordering
    send_request(qsb_pkg::CMD_POP, 32'sd0, 7'd0);
    send_request(qsb_pkg::CMD_READ, 32'sd0, 7'd0);
    send_request(CMD_UNUSED, -32'sd1, 7'd127);
    send_request(qsb_pkg::CMD_PUSH, 32'sh7fffffff, 7'd0);
    send_request(qsb_pkg::CMD_PUSH, 32'sh80000000, 7'd127);
    send_request(qsb_pkg::CMD_PUSH, -32'sd1, 7'd0);
    send_request(qsb_pkg::CMD_PUSH, 32'sd0, 7'd0);
    send_request(qsb_pkg::CMD_PUSH, 32'sd1, 7'd0);
    send_request(qsb_pkg::CMD_READ, 32'sd0, 7'd0);
    send_request(qsb_pkg::CMD_READ, 32'sd0, 7'd4);
    send_request(qsb_pkg::CMD_READ, 32'sd0, 7'd5);
    send_request(qsb_pkg::CMD_READ, 32'sd0, 7'd127);
    send_request(qsb_pkg::CMD_POP, 32'sd0, 7'd0);
    send_request(qsb_pkg::CMD_POP, 32'sd0, 7'd0);

    // switch to stack with three words held
    write_mode(1'b1);
    send_request(qsb_pkg::CMD_POP, 32'sd0, 7'd0);
    send_request(qsb_pkg::CMD_READ, 32'sd0, 7'd0);
    send_request(qsb_pkg::CMD_PUSH, 32'sh5a5a5a5a, 7'd0);
    send_request(qsb_pkg::CMD_POP, 32'sd0, 7'd0);
    send_request(qsb_pkg::CMD_POP, 32'sd0, 7'd0);
    send_request(qsb_pkg::CMD_POP, 32'sd0, 7'd0);
    send_request(qsb_pkg::CMD_POP, 32'sd0, 7'd0);
    send_request(CMD_UNUSED, 32'sh12345678, 7'd127);
    send_request(qsb_pkg::CMD_PUSH, 32'sha5a5a5a5, 7'd0);
    send_request(qsb_pkg::CMD_READ, 32'sd0, 7'd0);

    // queue mode, balanced mix
    write_mode(1'b0);
    run_random(80, 40, 30);

    // stack mode, fill to full; back-to-back while the result side holds off
    write_mode(1'b1);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_random(60, 85, 3);
    long_hold_tgl = !long_hold_tgl;
    run_random(50, 85, 3);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    run_random(60, 85, 3);

    // queue mode with the buffer full, drain it
    write_mode(1'b0);
    run_random(160, 5, 85);

    // stack mode, mixed, past empty
    write_mode(1'b1);
    tx_idle_en = 1'b0;
    run_random(40, 30, 45);

    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/qsb_pkg.sv
rtl/core/qsb_if.sv
rtl/core/qsb_fifo.sv
rtl/core/qsb_front.sv
rtl/core/qsb_back.sv
rtl/core/queue_stack_buffer_core.sv
tb/sv/qsb_scoreboard.sv
tb/sv/tb_queue_stack_buffer_core.sv
